// ----- design/cbg_pkg.sv -----
// Shared types and constants for the coprime base generator.
package cbg_pkg;

    localparam int FIELD_BITS    = 32;
    localparam int CFG_ADDR_BITS = 2;

    localparam logic [CFG_ADDR_BITS-1:0] REG_MODULUS_N  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PRIME_ONLY = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_BASE_COUNT = 2'd2;

    localparam logic [FIELD_BITS-1:0] MODULUS_RESET    = 32'd15;
    localparam logic [FIELD_BITS-1:0] BASE_COUNT_RESET = 32'd8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_TEST,
        S_GCD_DIV,
        S_GCD_WAIT,
        S_PRM_DIV,
        S_PRM_WAIT,
        S_NEXT,
        S_FINISH
    } cbg_state_t;

endpackage

// ----- design/cbg_divider.sv -----
// Shift-subtract divider, one quotient bit per cycle, shared for gcd and trial division.
module cbg_divider #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_BITS = $clog2(WIDTH + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0]    quo_reg, quo_next;
    logic [WIDTH-1:0]    rem_reg, rem_next;
    logic [WIDTH-1:0]    dsr_reg, dsr_next;
    logic [WIDTH:0]      shifted;
    logic [WIDTH:0]      diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[WIDTH-1]};
        diff      = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start && !busy_reg)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_BITS'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[WIDTH])
            begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- design/coprime_base_generator.sv -----
// Top level: request sequencer, configuration registers and result register.
// Each request beat searches upward from the stored candidate for the next value coprime to
// modulus_n (and prime when prime_only is set) and returns one result beat. All divisions
// run on one shift-subtract divider of W = max(VALUE_BITS, 32) bits. A candidate costs one
// division per Euclid step (at most about 1.44 * W steps) and, in prime mode, one division per
// trial divisor up to the square root of the candidate. The block takes no new request until
// the current result is in the output register, which holds it while the consumer stalls.
module coprime_base_generator #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [cbg_pkg::CFG_ADDR_BITS-1:0]       cfg_addr,
    input  logic [cbg_pkg::FIELD_BITS-1:0]          cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    restart,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [cbg_pkg::FIELD_BITS-1:0]          base_value,
    output logic [cbg_pkg::FIELD_BITS-1:0]          base_index,
    output logic                                    is_last,
    output logic                                    exhausted
);

    localparam int FB = cbg_pkg::FIELD_BITS;
    localparam int W  = (VALUE_BITS > FB) ? VALUE_BITS : FB;
    localparam logic [VALUE_BITS-1:0] VALUE_TOP = {VALUE_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0] VALUE_TWO = VALUE_BITS'(2);

    cbg_pkg::cbg_state_t state_reg, state_next;

    logic [FB-1:0]         modulus_reg, modulus_next;
    logic                  prime_reg, prime_next;
    logic [FB-1:0]         limit_reg, limit_next;
    logic [VALUE_BITS-1:0] cand_reg, cand_next;
    logic [FB-1:0]         count_reg, count_next;

    logic [VALUE_BITS-1:0] cur_reg, cur_next;
    logic [W-1:0]          gx_reg, gx_next;
    logic [W-1:0]          gy_reg, gy_next;
    logic [VALUE_BITS-1:0] d_reg, d_next;

    logic [FB-1:0]         res_value_reg, res_value_next;
    logic [FB-1:0]         res_index_reg, res_index_next;
    logic                  res_last_reg, res_last_next;
    logic                  res_exh_reg, res_exh_next;

    logic                  out_valid_reg, out_valid_next;
    logic [FB-1:0]         out_value_reg, out_value_next;
    logic [FB-1:0]         out_index_reg, out_index_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_exh_reg, out_exh_next;

    logic                  div_start;
    logic [W-1:0]          div_dividend;
    logic [W-1:0]          div_divisor;
    logic                  div_done;
    logic [W-1:0]          div_quotient;
    logic [W-1:0]          div_remainder;

    logic                  in_beat;
    logic                  out_free;
    logic                  exh_now;
    logic                  rem_zero;
    logic                  gcd_one;
    logic                  d_past_root;
    logic                  found;
    logic [FB:0]           count_inc;

    cbg_divider #(
        .WIDTH (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign in_beat     = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign exh_now     = (count_reg >= limit_reg) || (modulus_reg == '0);
    assign rem_zero    = (div_remainder == '0);
    assign gcd_one     = (gx_reg == W'(1));
    assign d_past_root = (W'(d_reg) > div_quotient);
    assign count_inc   = {1'b0, count_reg} + (FB+1)'(1);
    assign found       = ((state_reg == cbg_pkg::S_GCD_WAIT) && div_done && rem_zero
                          && gcd_one && !prime_reg)
                      || ((state_reg == cbg_pkg::S_PRM_WAIT) && div_done && d_past_root);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbg_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = cbg_pkg::S_CHECK;
            end
            cbg_pkg::S_CHECK:
            begin
                state_next = exh_now ? cbg_pkg::S_FINISH : cbg_pkg::S_TEST;
            end
            cbg_pkg::S_TEST:
            begin
                state_next = (cur_reg == VALUE_TOP) ? cbg_pkg::S_FINISH : cbg_pkg::S_GCD_DIV;
            end
            cbg_pkg::S_GCD_DIV:
            begin
                state_next = cbg_pkg::S_GCD_WAIT;
            end
            cbg_pkg::S_GCD_WAIT:
            begin
                if (div_done)
                begin
                    if (!rem_zero)
                        state_next = cbg_pkg::S_GCD_DIV;
                    else if (!gcd_one)
                        state_next = cbg_pkg::S_NEXT;
                    else if (prime_reg)
                        state_next = cbg_pkg::S_PRM_DIV;
                    else
                        state_next = cbg_pkg::S_FINISH;
                end
            end
            cbg_pkg::S_PRM_DIV:
            begin
                state_next = cbg_pkg::S_PRM_WAIT;
            end
            cbg_pkg::S_PRM_WAIT:
            begin
                if (div_done)
                begin
                    if (d_past_root)
                        state_next = cbg_pkg::S_FINISH;
                    else if (rem_zero)
                        state_next = cbg_pkg::S_NEXT;
                    else
                        state_next = cbg_pkg::S_PRM_DIV;
                end
            end
            cbg_pkg::S_NEXT:
            begin
                state_next = cbg_pkg::S_TEST;
            end
            cbg_pkg::S_FINISH:
            begin
                if (out_free)
                    state_next = cbg_pkg::S_IDLE;
            end
            default:
            begin
                state_next = cbg_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = (state_reg != cbg_pkg::S_IDLE);
        div_start    = 1'b0;
        div_dividend = gy_reg;
        div_divisor  = gx_reg;
        case (state_reg)
            cbg_pkg::S_GCD_DIV:
            begin
                div_start = 1'b1;
            end
            cbg_pkg::S_PRM_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = W'(cur_reg);
                div_divisor  = W'(d_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        modulus_next   = modulus_reg;
        prime_next     = prime_reg;
        limit_next     = limit_reg;
        cand_next      = cand_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        gx_next        = gx_reg;
        gy_next        = gy_reg;
        d_next         = d_reg;
        res_value_next = res_value_reg;
        res_index_next = res_index_reg;
        res_last_next  = res_last_reg;
        res_exh_next   = res_exh_reg;
        out_value_next = out_value_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        out_exh_next   = out_exh_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cfg_we)
        begin
            case (cfg_addr)
                cbg_pkg::REG_MODULUS_N:  modulus_next = cfg_data;
                cbg_pkg::REG_PRIME_ONLY: prime_next   = cfg_data[0];
                cbg_pkg::REG_BASE_COUNT: limit_next   = cfg_data;
                default:                 modulus_next = modulus_reg;
            endcase
        end

        if (in_beat && restart)
        begin
            cand_next  = VALUE_TWO;
            count_next = '0;
        end

        case (state_reg)
            cbg_pkg::S_CHECK:
            begin
                res_value_next = '0;
                res_index_next = '0;
                res_last_next  = 1'b0;
                res_exh_next   = 1'b1;
                cur_next       = (cand_reg < VALUE_TWO) ? VALUE_TWO : cand_reg;
            end
            cbg_pkg::S_TEST:
            begin
                gx_next = W'(cur_reg);
                gy_next = W'(modulus_reg);
                d_next  = VALUE_TWO;
                if (cur_reg == VALUE_TOP)
                    cand_next = VALUE_TOP;
            end
            cbg_pkg::S_GCD_WAIT:
            begin
                if (div_done && !rem_zero)
                begin
                    gy_next = gx_reg;
                    gx_next = div_remainder;
                end
            end
            cbg_pkg::S_PRM_WAIT:
            begin
                if (div_done && !d_past_root && !rem_zero)
                    d_next = d_reg + VALUE_BITS'(1);
            end
            cbg_pkg::S_NEXT:
            begin
                cur_next = cur_reg + VALUE_BITS'(1);
            end
            cbg_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_index_next = res_index_reg;
                    out_last_next  = res_last_reg;
                    out_exh_next   = res_exh_reg;
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase

        if (found)
        begin
            res_value_next = FB'(cur_reg);
            res_index_next = count_reg;
            res_last_next  = (count_inc == {1'b0, limit_reg});
            res_exh_next   = 1'b0;
            count_next     = count_inc[FB-1:0];
            cand_next      = cur_reg + VALUE_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cbg_pkg::S_IDLE;
            modulus_reg   <= cbg_pkg::MODULUS_RESET;
            prime_reg     <= 1'b0;
            limit_reg     <= cbg_pkg::BASE_COUNT_RESET;
            cand_reg      <= VALUE_TWO;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            modulus_reg   <= modulus_next;
            prime_reg     <= prime_next;
            limit_reg     <= limit_next;
            cand_reg      <= cand_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        gx_reg        <= gx_next;
        gy_reg        <= gy_next;
        d_reg         <= d_next;
        res_value_reg <= res_value_next;
        res_index_reg <= res_index_next;
        res_last_reg  <= res_last_next;
        res_exh_reg   <= res_exh_next;
        out_value_reg <= out_value_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
        out_exh_reg   <= out_exh_next;
    end

    assign out_valid  = out_valid_reg;
    assign base_value = out_value_reg;
    assign base_index = out_index_reg;
    assign is_last    = out_last_reg;
    assign exhausted  = out_exh_reg;

`ifndef NO_ASSERTIONS
    a_beat_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> state_reg == cbg_pkg::S_CHECK)
        else $error("request beat did not start a search");

    a_done_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == cbg_pkg::S_GCD_WAIT || state_reg == cbg_pkg::S_PRM_WAIT))
        else $error("divider finished outside a wait state");

    a_exhausted_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exhausted |-> base_value == '0 && base_index == '0 && !is_last)
        else $error("exhausted beat carries a base");

    a_base_at_least_two: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !exhausted && VALUE_BITS <= FB |-> base_value >= FB'(2))
        else $error("delivered base below two");

    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        found |-> count_reg < limit_reg && cur_reg != VALUE_TOP)
        else $error("base found past the count or at the range top");
`endif

endmodule

// ----- test/coprime_base_generator_tb.sv -----
// Self-checking testbench for the coprime base generator: directed table, then random sequences.
module coprime_base_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] SEARCH_TOP   = 64'h0000_0000_FFFF_FFFF;
    localparam int          CYCLE_LIMIT  = 20_000_000;
    localparam int          LONG_HOLD    = 1500;
    localparam int          SETTLE       = 8;
    localparam int          RANDOM_ITEMS = 800;
    localparam int          N_DIRECTED   = 24;
    localparam logic [31:0] PRIMORIAL_23 = 32'd223092870;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] index;
        logic        last;
        logic        exh;
    } base_beat_t;

    typedef struct packed {
        logic [31:0] modulus;
        logic        prime;
        logic [31:0] count;
        logic        rs;
        logic        typed;
        base_beat_t  want;
    } table_row_t;

    localparam base_beat_t NO_BASE = '{32'd0, 32'd0, 1'b0, 1'b1};

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [cbg_pkg::CFG_ADDR_BITS-1:0] cfg_addr = cbg_pkg::REG_MODULUS_N;
    logic [cbg_pkg::FIELD_BITS-1:0]    cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic                              restart = 1'b0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [cbg_pkg::FIELD_BITS-1:0]    base_value;
    logic [cbg_pkg::FIELD_BITS-1:0]    base_index;
    logic                              is_last;
    logic                              exhausted;

    logic       row_typed = 1'b0;
    base_beat_t row_want = NO_BASE;

    bit [31:0] cfg_modulus = cbg_pkg::MODULUS_RESET;
    bit        cfg_prime = 1'b0;
    bit [31:0] cfg_count = cbg_pkg::BASE_COUNT_RESET;
    bit [63:0] cand_next = 64'd2;
    bit [31:0] served_count = 32'd0;

    base_beat_t expected_bases[$];
    table_row_t directed_rows [N_DIRECTED];

    int cycle_count = 0;
    int mismatches = 0;
    int requests_seen = 0;
    int bases_seen = 0;
    int last_seen = 0;
    int prime_bases = 0;
    int exhausted_seen = 0;
    int settings_applied = 0;
    int hold_requests = 0;
    int burst_left = 0;

    coprime_base_generator i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .base_value (base_value),
        .base_index (base_index),
        .is_last    (is_last),
        .exhausted  (exhausted)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit [63:0] common_divisor(input bit [63:0] a, input bit [63:0] b);
        bit [63:0] x;
        bit [63:0] y;
        bit [63:0] t;
        x = a;
        y = b;
        while (x != 0)
        begin
            t = x;
            x = y % x;
            y = t;
        end
        return y;
    endfunction

    function automatic bit passes_trial_division(input bit [63:0] n);
        bit [63:0] d;
        if (n < 2)
            return 1'b0;
        for (d = 2; d <= n / d; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic base_beat_t next_base(input logic rs);
        base_beat_t r;
        bit [63:0]  c;
        r = NO_BASE;
        if (rs)
        begin
            cand_next = 64'd2;
            served_count = 32'd0;
        end
        if (served_count >= cfg_count || cfg_modulus == 0)
            return r;
        c = cand_next & SEARCH_TOP;
        if (c < 2)
            c = 64'd2;
        while (c < SEARCH_TOP)
        begin
            if (common_divisor(c, {32'd0, cfg_modulus}) == 1
                && (!cfg_prime || passes_trial_division(c)))
            begin
                r.value = c[31:0];
                r.index = served_count;
                r.last  = ({1'b0, served_count} + 33'd1) == {1'b0, cfg_count};
                r.exh   = 1'b0;
                served_count = served_count + 32'd1;
                cand_next = c + 64'd1;
                return r;
            end
            c++;
        end
        cand_next = SEARCH_TOP;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        base_beat_t got;
        base_beat_t want;
        base_beat_t predicted;
        cycle_count++;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{base_value, base_index, is_last, exhausted};
                if (expected_bases.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected result beat, expected none, actual %0d",
                             $time, got.value);
                end
                else
                begin
                    want = expected_bases.pop_front();
                    check_field("base_value", want.value, got.value);
                    check_field("base_index", want.index, got.index);
                    check_field("is_last", {31'd0, want.last}, {31'd0, got.last});
                    check_field("exhausted", {31'd0, want.exh}, {31'd0, got.exh});
                end
            end
            if (in_valid && !in_stall)
            begin
                predicted = next_base(restart);
                requests_seen++;
                if (predicted.exh)
                    exhausted_seen++;
                else
                begin
                    bases_seen++;
                    if (predicted.last)
                        last_seen++;
                    if (cfg_prime)
                        prime_bases++;
                end
                expected_bases.push_back(row_typed ? row_want : predicted);
            end
        end
    end

    initial
    begin : consumer
        int hold_left;
        int run_left;
        int mode;
        int holds_served;
        int tick;
        hold_left = 0;
        run_left = 0;
        mode = 0;
        holds_served = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_left == 0 && holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    run_left = $urandom_range(1, 40);
                end
                run_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ((tick % 5) < 2);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Run stopped after %0d cycles with %0d results outstanding",
                 cycle_count, expected_bases.size());
        $display("Regression FAIL");
        $finish;
    end

    task automatic issue_item(input logic rs, input logic typed, input base_beat_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid  <= 1'b1;
        restart   <= rs;
        row_typed <= typed;
        row_want  <= want;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bases.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic set_config(input logic [31:0] m, input logic p, input logic [31:0] n);
        logic [31:0] noise;
        noise = $urandom;
        cfg_we   <= 1'b1;
        cfg_addr <= cbg_pkg::REG_MODULUS_N;
        cfg_data <= m;
        @(posedge clk);
        cfg_addr <= cbg_pkg::REG_PRIME_ONLY;
        cfg_data <= {noise[31:1], p};
        @(posedge clk);
        cfg_addr <= cbg_pkg::REG_BASE_COUNT;
        cfg_data <= n;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_modulus = m;
        cfg_prime = p;
        cfg_count = n;
        settings_applied++;
    endtask

    initial
    begin : stimulus
        int          items_sent;
        int          seq_len;
        int          k;
        bit          pressure_done;
        logic        rs;
        logic [31:0] m;
        logic        p;
        logic [31:0] n;

        directed_rows = '{
            '{32'd15, 1'b0, 32'd8, 1'b0, 1'b1, '{32'd2, 32'd0, 1'b0, 1'b0}},
            '{32'd15, 1'b0, 32'd8, 1'b0, 1'b1, '{32'd4, 32'd1, 1'b0, 1'b0}},
            '{32'd15, 1'b0, 32'd8, 1'b0, 1'b0, NO_BASE},
            '{32'd15, 1'b0, 32'd8, 1'b1, 1'b1, '{32'd2, 32'd0, 1'b0, 1'b0}},
            '{32'd0, 1'b0, 32'd8, 1'b0, 1'b1, NO_BASE},
            '{32'd0, 1'b0, 32'd8, 1'b1, 1'b1, NO_BASE},
            '{32'd1, 1'b0, 32'd2, 1'b1, 1'b1, '{32'd2, 32'd0, 1'b0, 1'b0}},
            '{32'd1, 1'b0, 32'd2, 1'b0, 1'b1, '{32'd3, 32'd1, 1'b1, 1'b0}},
            '{32'd1, 1'b0, 32'd2, 1'b0, 1'b1, NO_BASE},
            '{32'd1, 1'b0, 32'd0, 1'b1, 1'b1, NO_BASE},
            '{32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, '{32'd2, 32'd0, 1'b0, 1'b0}},
            '{32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_BASE},
            '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_BASE},
            '{32'hFFFF_FFFE, 1'b1, 32'd3, 1'b1, 1'b0, NO_BASE},
            '{32'hFFFF_FFFE, 1'b1, 32'd3, 1'b0, 1'b0, NO_BASE},
            '{32'hFFFF_FFFE, 1'b1, 32'd3, 1'b0, 1'b0, NO_BASE},
            '{32'hFFFF_FFFE, 1'b1, 32'd3, 1'b0, 1'b1, NO_BASE},
            '{32'hFFFF_FFFE, 1'b1, 32'd1, 1'b1, 1'b0, NO_BASE},
            '{32'hFFFF_FFFE, 1'b1, 32'd1, 1'b0, 1'b1, NO_BASE},
            '{PRIMORIAL_23, 1'b1, 32'd4, 1'b1, 1'b0, NO_BASE},
            '{PRIMORIAL_23, 1'b1, 32'd4, 1'b0, 1'b0, NO_BASE},
            '{PRIMORIAL_23, 1'b0, 32'd16, 1'b0, 1'b0, NO_BASE},
            '{PRIMORIAL_23, 1'b0, 32'd2, 1'b0, 1'b1, NO_BASE},
            '{32'd2, 1'b1, 32'd5, 1'b1, 1'b0, NO_BASE}
        };
        pressure_done = 1'b0;
        items_sent = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            if (directed_rows[r].modulus != cfg_modulus || directed_rows[r].prime != cfg_prime
                || directed_rows[r].count != cfg_count)
            begin
                wait_all_results();
                set_config(directed_rows[r].modulus, directed_rows[r].prime,
                           directed_rows[r].count);
            end
            issue_item(directed_rows[r].rs, directed_rows[r].typed, directed_rows[r].want);
        end

        while (items_sent < RANDOM_ITEMS)
        begin
            wait_all_results();
            case ($urandom_range(0, 9))
                0: m = 32'd0;
                1: m = 32'd1;
                2: m = 32'hFFFF_FFFF;
                3: m = 32'hFFFF_FFFE;
                4: m = PRIMORIAL_23;
                5, 6: m = $urandom;
                default: m = $urandom_range(2, 200);
            endcase
            p = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 7))
                0: n = 32'd0;
                1: n = 32'hFFFF_FFFF;
                2: n = $urandom;
                3: n = 32'd1;
                default: n = $urandom_range(2, 20);
            endcase
            set_config(m, p, n);

            if (!pressure_done && items_sent >= RANDOM_ITEMS / 3)
            begin
                pressure_done = 1'b1;
                hold_requests <= hold_requests + 1;
                burst_left = 30;
                for (k = 0; k < 30; k++)
                begin
                    issue_item(k == 0, 1'b0, NO_BASE);
                    items_sent++;
                end
                wait_all_results();
            end

            repeat ($urandom_range(3, 8))
            begin
                seq_len = $urandom_range(1, 24);
                for (k = 0; k < seq_len; k++)
                begin
                    if (k == 0)
                        rs = ($urandom_range(0, 9) != 0);
                    else
                        rs = ($urandom_range(0, 19) == 0);
                    issue_item(rs, 1'b0, NO_BASE);
                    items_sent++;
                end
                if ($urandom_range(0, 5) == 0)
                    wait_all_results();
            end
        end

        wait_all_results();
        repeat (50) @(posedge clk);

        $display("Covered %0d requests: %0d bases (%0d flagged last, %0d prime-only), %0d exhausted",
                 requests_seen, bases_seen, last_seen, prime_bases, exhausted_seen);
        $display("Applied %0d register settings, %0d long output hold-offs, %0d cycles",
                 settings_applied, hold_requests, cycle_count);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
